[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the car command encoder.
// No dependencies; define SYNTH to compile the assertions away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/ccbe_pkg.sv]
// Types, codes and helper functions for the car command byte encoder.
// No dependencies; used by every module of the block.
package ccbe_pkg;

    localparam int MAX_CARS_DEFAULT = 1024;

    localparam int ADDR_W     = 10;
    localparam int SPEED_W    = 5;
    localparam int FUNC_W     = 12;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int COUNT_W    = 11;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAR_COUNT = 2'd1;

    localparam logic [COUNT_W-1:0] CAR_COUNT_RST = 11'd1024;

    // Field codes
    localparam logic       REQ_CAR      = 1'b0;
    localparam logic       REQ_POWER    = 1'b1;
    localparam logic [1:0] DIR_STOP_REV = 2'd2;
    localparam logic       DIR_REVERSE  = 1'b0;
    localparam logic       LINK_FIRST   = 1'b0;

    // Fixed command bytes
    localparam logic [BYTE_W-1:0] PWR_OFF_BYTE = 8'd240;
    localparam logic [BYTE_W-1:0] STOP_BYTE    = 8'd200;

    // Pending message bits, in emission order
    localparam int PEND_W       = 4;
    localparam int PB_SPEED     = 0;
    localparam int PB_FN_LOW    = 1;
    localparam int PB_FN_HIGH   = 2;
    localparam int PB_POWER_OFF = 3;

    typedef enum logic [1:0] {
        MSG_SPEED     = 2'd0,
        MSG_FN_LOW    = 2'd1,
        MSG_FN_HIGH   = 2'd2,
        MSG_POWER_OFF = 2'd3
    } msg_sel_t;

    typedef struct packed {
        logic               req_type;
        logic [ADDR_W-1:0]  car_addr;
        logic [SPEED_W-1:0] speed_step;
        logic [1:0]         dir_code;
        logic [FUNC_W-1:0]  func_bits;
        logic               power_on;
    } request_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_addr_low;
        logic [BYTE_W-1:0] byte_addr_high;
        logic [BYTE_W-1:0] byte_payload;
        logic              last_of_run;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic     clear_step;
        logic     capture;
        logic     read;
        logic     eval;
        logic     emit;
        msg_sel_t msg_sel;
        logic     last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [PEND_W-1:0] pend;
        logic              clear_last;
    } status_t;

    // Map a speed step to its command byte
    function automatic logic [BYTE_W-1:0] speed_code(input logic [SPEED_W-1:0] s);
        logic [BYTE_W-1:0] s8;
        s8 = BYTE_W'(s);
        if (s < 5'd8)        return s8 + 8'd200;
        else if (s < 5'd16)  return s8 + 8'd208;
        else if (s < 5'd24)  return s8 + 8'd216;
        else if (s <= 5'd28) return s8 + 8'd224;
        else                 return STOP_BYTE;
    endfunction

endpackage

[rtl/core/ccbe_ctrl.sv]
// Controller state machine of the car command encoder: clear sweep,
// request sequencing and message selection. Depends on ccbe_pkg.
module ccbe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output ccbe_pkg::cmd_t    cmd,
    input  ccbe_pkg::status_t status
);
    import ccbe_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_EVAL  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [PEND_W-1:0] pend_rest;
    msg_sel_t          sel;

    // Pick the next message in order and drop it from the pending set
    always_comb
    begin
        pend_rest = pend_reg;
        if (pend_reg[PB_SPEED])
        begin
            sel = MSG_SPEED;
            pend_rest[PB_SPEED] = 1'b0;
        end
        else if (pend_reg[PB_FN_LOW])
        begin
            sel = MSG_FN_LOW;
            pend_rest[PB_FN_LOW] = 1'b0;
        end
        else if (pend_reg[PB_FN_HIGH])
        begin
            sel = MSG_FN_HIGH;
            pend_rest[PB_FN_HIGH] = 1'b0;
        end
        else
        begin
            sel = MSG_POWER_OFF;
            pend_rest[PB_POWER_OFF] = 1'b0;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        cmd            = '0;
        cmd.msg_sel    = sel;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval  = 1'b1;
                pend_next = status.pend;
                state_next = (status.pend == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit  = 1'b1;
                cmd.last  = (pend_rest == '0);
                pend_next = pend_rest;
                if (pend_rest == '0)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

[rtl/core/ccbe_datapath.sv]
// Datapath of the car command encoder: per-car entry memory, request
// capture, change detection and command byte formation. Depends on ccbe_pkg.
module ccbe_datapath #(
    parameter int MAX_CARS = ccbe_pkg::MAX_CARS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ccbe_pkg::cmd_t                 cmd,
    output ccbe_pkg::status_t              status,
    input  ccbe_pkg::request_t             request,
    input  logic                           link_mode,
    input  logic [ccbe_pkg::COUNT_W-1:0]   car_count,
    output ccbe_pkg::result_t              result,
    output logic                           result_valid
);
    import ccbe_pkg::*;

    localparam int AW = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int XW = (AW > ADDR_W) ? AW : ADDR_W;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               dir;
        logic [FUNC_W-1:0]  func;
    } entry_t;

    entry_t   mem [MAX_CARS];
    entry_t   rd_reg;
    request_t req_reg;
    logic [AW-1:0] clr_cnt_reg;
    result_t  result_reg;
    logic     valid_reg;

    logic [XW-1:0]      addr_x;
    logic [AW-1:0]      idx;
    logic               in_range;
    logic [SPEED_W-1:0] speed_eff;
    logic               dir_new;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    entry_t             wr_data;
    logic [BYTE_W-1:0]  lo_byte;
    logic [BYTE_W-1:0]  hi_byte;
    logic [PEND_W-1:0]  pend;
    result_t            res_next;

    // Address decode and range check
    assign addr_x   = XW'(req_reg.car_addr);
    assign idx      = addr_x[AW-1:0];
    assign in_range = ({1'b0, req_reg.car_addr} < car_count)
                   && (32'(req_reg.car_addr) < 32'(MAX_CARS));

    // Effective speed and direction after the stop-and-reverse code
    always_comb
    begin
        if (req_reg.dir_code == DIR_STOP_REV)
        begin
            speed_eff = '0;
            dir_new   = ~rd_reg.dir;
        end
        else
        begin
            speed_eff = req_reg.speed_step;
            dir_new   = (req_reg.dir_code != 2'd0);
        end
    end

    // Detect which messages are due
    always_comb
    begin
        pend = '0;
        if (req_reg.req_type == REQ_POWER)
        begin
            pend[PB_POWER_OFF] = !req_reg.power_on && (link_mode == LINK_FIRST);
        end
        else if (in_range)
        begin
            pend[PB_SPEED]   = (speed_eff != rd_reg.speed);
            pend[PB_FN_LOW]  = (req_reg.func_bits[6:1] != rd_reg.func[6:1]);
            pend[PB_FN_HIGH] = (link_mode == LINK_FIRST)
                && ({req_reg.func_bits[11:7], req_reg.func_bits[0]}
                    != {rd_reg.func[11:7], rd_reg.func[0]});
        end
    end

    assign status.pend       = pend;
    assign status.clear_last = (clr_cnt_reg == AW'(MAX_CARS - 1));

    // Memory write port: clear sweep or entry write-back
    always_comb
    begin
        if (cmd.clear_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = cmd.eval && (req_reg.req_type == REQ_CAR) && in_range;
            wr_addr = idx;
            wr_data = '{speed: speed_eff, dir: dir_new, func: req_reg.func_bits};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (cmd.read)
            rd_reg <= mem[idx];
    end

    // Capture the accepted request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= request;
    end

    // Form the command bytes
    assign lo_byte = {2'b00, req_reg.car_addr[5:0]};
    assign hi_byte = {4'b0100, req_reg.car_addr[9:6]};

    always_comb
    begin
        res_next.last_of_run = cmd.last;
        case (cmd.msg_sel)
            MSG_SPEED:
            begin
                res_next.byte_addr_low  = lo_byte;
                res_next.byte_addr_high = hi_byte;
                res_next.byte_payload   = speed_code(speed_eff);
            end
            MSG_FN_LOW:
            begin
                res_next.byte_addr_low  = lo_byte;
                res_next.byte_addr_high = hi_byte;
                res_next.byte_payload   = {2'b10, req_reg.func_bits[6:1]};
            end
            MSG_FN_HIGH:
            begin
                res_next.byte_addr_low  = lo_byte;
                res_next.byte_addr_high = hi_byte | 8'd32;
                res_next.byte_payload   = {2'b10, req_reg.func_bits[11:7],
                                           req_reg.func_bits[0]};
            end
            MSG_POWER_OFF:
            begin
                res_next.byte_addr_low  = PWR_OFF_BYTE;
                res_next.byte_addr_high = PWR_OFF_BYTE;
                res_next.byte_payload   = '0;
            end
            default:
            begin
                res_next.byte_addr_low  = '0;
                res_next.byte_addr_high = '0;
                res_next.byte_payload   = '0;
            end
        endcase
    end

    // Register the result on each emit and hold it until the next emit
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            result_reg <= res_next;
    end

    // Clear counter and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            if (cmd.clear_step)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

[rtl/core/car_command_byte_encoder.sv]
// Top level of the car command byte encoder; depends on ccbe_pkg, ccbe_ctrl,
// ccbe_datapath and assert_macros.svh. After reset the entry memory is
// cleared one entry a cycle, and busy stays high until the sweep ends.
// An accepted request passes the read and evaluate states, then emits
// n = 0..3 results, one per cycle, through the single output register;
// the block accepts the next request when it is back in idle.
`include "assert_macros.svh"

module car_command_byte_encoder #(
    parameter int MAX_CARS = ccbe_pkg::MAX_CARS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ccbe_pkg::request_t               request,
    output ccbe_pkg::result_t                result,
    output logic                             result_valid,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ccbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ccbe_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ccbe_pkg::*;

    cmd_t              cmd;
    status_t           status;
    logic              link_mode_reg;
    logic [COUNT_W-1:0] car_count_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_mode_reg <= LINK_FIRST;
            car_count_reg <= CAR_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LINK_MODE: link_mode_reg <= cfg_data[0];
                CFG_CAR_COUNT: car_count_reg <= cfg_data[COUNT_W-1:0];
                default:       ;
            endcase
        end
    end

    ccbe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    ccbe_datapath #(
        .MAX_CARS (MAX_CARS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .request      (request),
        .link_mode    (link_mode_reg),
        .car_count    (car_count_reg),
        .result       (result),
        .result_valid (result_valid)
    );

    // An accepted request keeps the block busy
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // Results only come out of work started while busy
    `ASSERT_IMPLIES(a_result_busy, clk, rst_n, result_valid, $past(busy))
    // Results of one request come back to back
    `ASSERT_NEXT(a_run_contiguous, clk, rst_n, result_valid && !result.last_of_run, result_valid)
    // A run ends with a gap before the next result
    `ASSERT_NEXT(a_run_gap, clk, rst_n, result_valid && result.last_of_run, !result_valid)

endmodule

[tb/car_command_byte_encoder_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for car_command_byte_encoder: predicts the command bytes of
// every accepted request and compares each strobed command against the prediction.
// Depends on ccbe_pkg and the encoder RTL.

module car_command_byte_encoder_test;
    import ccbe_pkg::*;

    localparam int NUM_CARS      = MAX_CARS_DEFAULT;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 12;
    localparam int NUM_PHASES    = 6;
    localparam int REQ_W         = $bits(request_t);

    localparam logic LINK_IR = ~LINK_FIRST;

    // Register indexes past the end of the map; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Per-phase settings; a negative car count means pick one at random
    localparam logic PHASE_LINK  [NUM_PHASES] = '{LINK_FIRST, LINK_IR, LINK_FIRST,
                                                  LINK_IR, LINK_FIRST, LINK_FIRST};
    localparam int   PHASE_COUNT [NUM_PHASES] = '{1024, 1024, -1, 2047, 0, 1024};
    localparam int   PHASE_ITEMS [NUM_PHASES] = '{85, 85, 85, 85, 30, 85};
    localparam int   PHASE_IDLE  [NUM_PHASES] = '{0, 79, 13, 0, 79, 13};

    // Per-car table mirror, register copy and queue of commands still due
    class car_command_tracker;
        bit [SPEED_W-1:0] speed_mem [NUM_CARS];
        bit               dir_mem   [NUM_CARS];
        bit [FUNC_W-1:0]  func_mem  [NUM_CARS];
        bit               link_mode;
        bit [COUNT_W-1:0] car_count;
        result_t          expected_cmds [$];
        int               errors;
        int               requests_seen;
        int               cmds_checked;
        int               reg_writes;

        function new();
            link_mode = LINK_FIRST;
            car_count = CAR_COUNT_RST;
        endfunction

        function bit [BYTE_W-1:0] encode_speed(input bit [SPEED_W-1:0] s);
            bit [BYTE_W-1:0] base;
            case (s[4:3])
                2'd0:    base = 8'd200;
                2'd1:    base = 8'd208;
                2'd2:    base = 8'd216;
                default: base = 8'd224;
            endcase
            if (s > 5'd28)
                return STOP_BYTE;
            return base + BYTE_W'(s);
        endfunction

        function void write_register(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            case (idx)
                CFG_LINK_MODE: link_mode = data[0];
                CFG_CAR_COUNT: car_count = data;
                default: ;
            endcase
        endfunction

        // Work out the commands one accepted request causes, then update the entry
        function void note_request(input request_t r);
            bit [SPEED_W-1:0] spd;
            bit               dir;
            bit [BYTE_W-1:0]  lo;
            bit [BYTE_W-1:0]  hi;
            bit [FUNC_W-1:0]  old_fn;
            bit [FUNC_W-1:0]  fn;
            result_t          cmds [$];
            result_t          c;
            requests_seen++;
            if (r.req_type == REQ_POWER)
            begin
                if (!r.power_on && link_mode == LINK_FIRST)
                begin
                    c.byte_addr_low  = PWR_OFF_BYTE;
                    c.byte_addr_high = PWR_OFF_BYTE;
                    c.byte_payload   = '0;
                    c.last_of_run    = 1'b1;
                    expected_cmds.push_back(c);
                end
                return;
            end
            if ({1'b0, r.car_addr} >= car_count)
                return;

            spd = r.speed_step;
            dir = |r.dir_code;
            if (r.dir_code == DIR_STOP_REV)
            begin
                spd = '0;
                dir = !dir_mem[r.car_addr];
            end
            lo     = {2'b00, r.car_addr[5:0]};
            hi     = 8'd64 + BYTE_W'(r.car_addr[9:6]);
            fn     = r.func_bits;
            old_fn = func_mem[r.car_addr];

            c.last_of_run = 1'b0;
            if (spd != speed_mem[r.car_addr])
            begin
                c.byte_addr_low  = lo;
                c.byte_addr_high = hi;
                c.byte_payload   = encode_speed(spd);
                cmds.push_back(c);
            end
            if (fn[6:1] != old_fn[6:1])
            begin
                c.byte_addr_low  = lo;
                c.byte_addr_high = hi;
                c.byte_payload   = {2'b10, fn[6:1]};
                cmds.push_back(c);
            end
            if (link_mode == LINK_FIRST && {fn[11:7], fn[0]} != {old_fn[11:7], old_fn[0]})
            begin
                c.byte_addr_low  = lo;
                c.byte_addr_high = hi + 8'd32;
                c.byte_payload   = {2'b10, fn[11:7], fn[0]};
                cmds.push_back(c);
            end
            if (cmds.size() != 0)
                cmds[cmds.size() - 1].last_of_run = 1'b1;
            foreach (cmds[k])
                expected_cmds.push_back(cmds[k]);

            speed_mem[r.car_addr] = spd;
            dir_mem[r.car_addr]   = dir;
            func_mem[r.car_addr]  = fn;
        endfunction

        // Compare one strobed command with the oldest one due
        function void check_command(input result_t got);
            result_t want;
            if (expected_cmds.size() == 0)
            begin
                errors++;
                $error("unexpected command %0d,%0d,%0d last=%0d", got.byte_addr_low,
                       got.byte_addr_high, got.byte_payload, got.last_of_run);
                return;
            end
            want = expected_cmds.pop_front();
            cmds_checked++;
            if (got.byte_addr_low !== want.byte_addr_low)
            begin
                errors++;
                $error("byte_addr_low: expected %0d, got %0d",
                       want.byte_addr_low, got.byte_addr_low);
            end
            if (got.byte_addr_high !== want.byte_addr_high)
            begin
                errors++;
                $error("byte_addr_high: expected %0d, got %0d",
                       want.byte_addr_high, got.byte_addr_high);
            end
            if (got.byte_payload !== want.byte_payload)
            begin
                errors++;
                $error("byte_payload: expected %0d, got %0d",
                       want.byte_payload, got.byte_payload);
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                errors++;
                $error("last_of_run: expected %0d, got %0d",
                       want.last_of_run, got.last_of_run);
            end
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    request_t              request      = '0;
    result_t               result;
    logic                  result_valid;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    car_command_tracker tracker;
    int                 stall_cycles = 0;

    always #6 clk = ~clk;

    car_command_byte_encoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result       (result),
        .result_valid (result_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Track accepted requests, register writes and strobed commands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                tracker.check_command(result);
            if (start && !busy)
                tracker.note_request(request);
            if (cfg_valid && cfg_ready)
                tracker.write_register(cfg_index, cfg_data);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || result_valid || (start && !busy) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic request_t car_req(input logic [ADDR_W-1:0] addr,
                                         input logic [SPEED_W-1:0] spd,
                                         input logic [1:0] dc,
                                         input logic [FUNC_W-1:0] fn);
        request_t r;
        r.req_type   = REQ_CAR;
        r.car_addr   = addr;
        r.speed_step = spd;
        r.dir_code   = dc;
        r.func_bits  = fn;
        r.power_on   = 1'($urandom);
        return r;
    endfunction

    function automatic request_t power_req(input logic on);
        request_t r;
        r          = request_t'(REQ_W'($urandom));
        r.req_type = REQ_POWER;
        r.power_on = on;
        return r;
    endfunction

    // Drive start and the request, then wait until the block is no longer busy; leave start high
    task automatic send_request(input request_t r);
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_cycle();
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop start, wait for every command due, then let a request with no output finish
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.expected_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        request_t         r;
        int               cc;
        int               idle_pct;
        bit [ADDR_W-1:0]  pool [6];
        bit [FUNC_W-1:0]  old_fn;

        tracker = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, speed band edges, each command kind
        write_cfg(CFG_LINK_MODE, {10'($urandom), LINK_FIRST});
        write_cfg(CFG_CAR_COUNT, CAR_COUNT_RST);
        send_request(car_req(10'd0, 5'd0, 2'd0, 12'h000));
        send_request(car_req(10'd0, 5'd28, 2'd1, 12'hFFF));
        send_request(car_req(10'd0, 5'd28, 2'd1, 12'hFFF));
        send_request(car_req(10'd1023, 5'd31, 2'd1, 12'h001));
        send_request(car_req(10'd1023, 5'd31, DIR_STOP_REV, 12'h001));
        send_request(car_req(10'd1023, 5'd7, 2'd3, 12'h07E));
        send_request(car_req(10'd64, 5'd8, 2'd0, 12'hF80));
        send_request(car_req(10'd64, 5'd15, 2'd0, 12'h040));
        send_request(car_req(10'd64, 5'd16, 2'd1, 12'h040));
        send_request(car_req(10'd64, 5'd23, 2'd1, 12'h001));
        send_request(car_req(10'd64, 5'd24, DIR_STOP_REV, 12'h001));
        send_request(car_req(10'd64, 5'd29, 2'd3, 12'h002));
        send_request(car_req(10'd65, 5'd1, 2'd0, 12'hF80));
        send_request(power_req(1'b0));
        send_request(power_req(1'b1));
        drain();

        // Infrared link: no power-off command, no F0/F7..F11 command
        write_cfg(CFG_LINK_MODE, {10'($urandom), LINK_IR});
        send_request(power_req(1'b0));
        send_request(car_req(10'd64, 5'd2, 2'd0, 12'hFFF));
        drain();

        // Address limit at zero and just around a mid value
        write_cfg(CFG_CAR_COUNT, 11'd0);
        send_request(car_req(10'd0, 5'd5, 2'd1, 12'h7FF));
        drain();
        write_cfg(CFG_CAR_COUNT, 11'd100);
        send_request(car_req(10'd99, 5'd3, 2'd1, 12'h555));
        send_request(car_req(10'd100, 5'd3, 2'd1, 12'hAAA));
        drain();
        write_cfg(CFG_SPARE_A, 11'($urandom));
        write_cfg(CFG_SPARE_B, 11'h7FF);

        // Random phases: requests mostly revisit a small set of cars
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            cc = (PHASE_COUNT[p] < 0) ? $urandom_range(1, 1023) : PHASE_COUNT[p];
            write_cfg(CFG_LINK_MODE, {10'($urandom), PHASE_LINK[p]});
            write_cfg(CFG_CAR_COUNT, 11'(cc));
            pool[0]  = '0;
            pool[1]  = '1;
            pool[2]  = 10'(cc - 1);
            pool[3]  = 10'(cc);
            pool[4]  = 10'($urandom);
            pool[5]  = 10'($urandom);
            idle_pct = PHASE_IDLE[p];
            for (int i = 0; i < PHASE_ITEMS[p]; i++)
            begin
                r          = request_t'(REQ_W'($urandom));
                r.req_type = ($urandom_range(9) == 0) ? REQ_POWER : REQ_CAR;
                r.car_addr = ($urandom_range(9) == 0) ? 10'($urandom) : pool[$urandom_range(5)];
                if ($urandom_range(2) == 0)
                    r.speed_step = tracker.speed_mem[r.car_addr];
                old_fn = tracker.func_mem[r.car_addr];
                case ($urandom_range(2))
                    0:       r.func_bits = 12'($urandom);
                    1:       r.func_bits = old_fn ^ (12'd1 << $urandom_range(11));
                    default: r.func_bits = old_fn;
                endcase
                // In every twenty requests, leave the last six back to back
                if (idle_pct != 0 && (i % 20) < 14)
                    while ($urandom_range(99) < idle_pct)
                        idle_cycle();
                send_request(r);
            end
            drain();
        end

        if (tracker.expected_cmds.size() != 0)
        begin
            tracker.errors++;
            $error("%0d commands never arrived", tracker.expected_cmds.size());
        end
        $display("Run covered %0d requests, %0d commands compared, %0d register writes,",
                 tracker.requests_seen, tracker.cmds_checked, tracker.reg_writes);
        $display("both link modes, car limits 0 to 2047, and sender gaps up to 79%% idle.");
        if (tracker.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ccbe_pkg.sv
rtl/core/ccbe_ctrl.sv
rtl/core/ccbe_datapath.sv
rtl/core/car_command_byte_encoder.sv
tb/car_command_byte_encoder_test.sv
